/* rtl/hvs_pkg.sv */
`default_nettype none

package hvs_pkg;

  // Build constants
  localparam int CHANNELS   = 4;   // active supply channels, 1..4
  localparam int LEVEL_BITS = 16;  // level resolution, 8..16

  localparam int SLOTS    = 4;     // output slots, fixed by the stream format
  localparam int SLOT_W   = 16;    // width of one voltage slot
  localparam int STEP_W   = 16;
  localparam int TICK_W   = 32;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_TUSER_W = 3;

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_TEST = 2'd1;
  localparam logic [1:0] CMD_BEAM = 2'd2;

  // Sequencer modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TEST = 2'd1;
  localparam logic [1:0] MODE_BEAM = 2'd2;

  // Event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_VSTEP = 3'd1;
  localparam logic [2:0] EV_FSTEP = 3'd2;
  localparam logic [2:0] EV_PASS  = 3'd3;
  localparam logic [2:0] EV_DONE  = 3'd4;
  localparam logic [2:0] EV_FAULT = 3'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_TARGETS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLT_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIL_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIL_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TICKS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PROT_EN      = 3'd6;

  typedef struct packed {
    logic [CFG_W-1:0]  voltage_targets;
    logic [STEP_W-1:0] volt_step;
    logic [STEP_W-1:0] filament_step;
    logic [TICK_W-1:0] step_ticks;
    logic [TICK_W-1:0] filament_step_ticks;
    logic [TICK_W-1:0] init_ticks;
    logic              protection_enable;
  } hvs_cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] filament_target;
    logic [3:0]  limit_flags;
  } hvs_item_t;

  typedef struct packed {
    logic [1:0]                   ramp_state;
    logic [SLOTS-1:0][SLOT_W-1:0] volt;
    logic [15:0]                  filament_level;
    logic                         filament_on;
    logic                         limit_set;
    logic [2:0]                   event_res;
  } hvs_result_t;

endpackage

`default_nettype wire

/* rtl/hvs_cfg_regs.sv */
`default_nettype none

module hvs_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [hvs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hvs_pkg::CFG_W-1:0]      cfg_data_i,
  output hvs_pkg::hvs_cfg_t                   cfg_o
);
  import hvs_pkg::*;

  hvs_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_VOLT_TARGETS: cfg_d.voltage_targets     = cfg_data_i;
        REG_VOLT_STEP:    cfg_d.volt_step           = cfg_data_i[STEP_W-1:0];
        REG_FIL_STEP:     cfg_d.filament_step       = cfg_data_i[STEP_W-1:0];
        REG_STEP_TICKS:   cfg_d.step_ticks          = cfg_data_i[TICK_W-1:0];
        REG_FIL_TICKS:    cfg_d.filament_step_ticks = cfg_data_i[TICK_W-1:0];
        REG_INIT_TICKS:   cfg_d.init_ticks          = cfg_data_i[TICK_W-1:0];
        REG_PROT_EN:      cfg_d.protection_enable   = cfg_data_i[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.voltage_targets     <= '0;
      cfg_q.volt_step           <= STEP_W'(1);
      cfg_q.filament_step       <= STEP_W'(1);
      cfg_q.step_ticks          <= '0;
      cfg_q.filament_step_ticks <= '0;
      cfg_q.init_ticks          <= '0;
      cfg_q.protection_enable   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/hvs_seq_core.sv */
`default_nettype none

module hvs_seq_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hvs_pkg::hvs_cfg_t  cfg_i,
  input  wire logic               advance_i,
  input  wire hvs_pkg::hvs_item_t item_i,
  output hvs_pkg::hvs_result_t    result_o
);
  import hvs_pkg::*;

  localparam int SUM_W = ((LEVEL_BITS > STEP_W) ? LEVEL_BITS : STEP_W) + 1;

  typedef logic [LEVEL_BITS-1:0] level_t;

  function automatic level_t sat_toward(level_t lvl, logic [STEP_W-1:0] stp, level_t goal);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(lvl) + SUM_W'(stp);
    if (sum > SUM_W'(goal)) return goal;
    return sum[LEVEL_BITS-1:0];
  endfunction

  logic [1:0]        mode_q, mode_d;
  level_t            lvl_q [CHANNELS];
  level_t            lvl_d [CHANNELS];
  level_t            tgt_q [CHANNELS];
  level_t            tgt_d [CHANNELS];
  level_t            step_lvl [CHANNELS];
  logic              zeroed_q, zeroed_d;
  level_t            fil_lvl_q, fil_lvl_d;
  level_t            fil_goal_q, fil_goal_d;
  logic              fil_en_q, fil_en_d;
  logic              beam_lim_q, beam_lim_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic [TICK_W-1:0] el_inc;
  logic [2:0]        ev;
  logic              all_zero, all_on, do_vstep, fault_hit;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_step
    assign step_lvl[g] = sat_toward(lvl_q[g], cfg_i.volt_step, tgt_q[g]);
  end

  assign el_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);

  always_comb begin
    mode_d     = mode_q;
    lvl_d      = lvl_q;
    tgt_d      = tgt_q;
    zeroed_d   = zeroed_q;
    fil_lvl_d  = fil_lvl_q;
    fil_goal_d = fil_goal_q;
    fil_en_d   = fil_en_q;
    beam_lim_d = beam_lim_q;
    elapsed_d  = elapsed_q;
    ev         = EV_NONE;
    do_vstep   = 1'b0;
    fault_hit  = 1'b0;
    all_zero   = 1'b1;
    all_on     = 1'b1;
    for (int i = 0; i < CHANNELS; i++) begin
      if (lvl_q[i] != '0) all_zero = 1'b0;
      if (lvl_q[i] != tgt_q[i]) all_on = 1'b0;
    end

    unique case (item_i.cmd)
      CMD_TEST, CMD_BEAM: begin
        for (int i = 0; i < CHANNELS; i++) begin
          lvl_d[i] = '0;
          tgt_d[i] = cfg_i.voltage_targets[SLOT_W*i +: LEVEL_BITS];
        end
        mode_d     = (item_i.cmd == CMD_BEAM) ? MODE_BEAM : MODE_TEST;
        zeroed_d   = 1'b1;
        fil_lvl_d  = '0;
        fil_goal_d = (item_i.cmd == CMD_BEAM) ? item_i.filament_target[LEVEL_BITS-1:0] : '0;
        fil_en_d   = 1'b0;
        beam_lim_d = (item_i.cmd == CMD_BEAM);
        elapsed_d  = '0;
      end
      CMD_TICK: begin
        elapsed_d = el_inc;
        if (mode_q == MODE_TEST || mode_q == MODE_BEAM) begin
          if (mode_q == MODE_BEAM && fil_goal_q != fil_lvl_q) begin
            // filament ramps first, voltages wait
            if (el_inc >= cfg_i.filament_step_ticks) begin
              if (fil_lvl_q == '0) begin
                fil_en_d   = 1'b1;
                beam_lim_d = 1'b1;
              end
              fil_lvl_d = sat_toward(fil_lvl_q, cfg_i.filament_step, fil_goal_q);
              elapsed_d = '0;
              ev        = EV_FSTEP;
            end
          end else if (all_zero) begin
            do_vstep = (el_inc >= cfg_i.init_ticks);
          end else if (!all_on) begin
            do_vstep = (el_inc >= cfg_i.step_ticks);
          end else begin
            mode_d = MODE_IDLE;
            if (mode_q == MODE_TEST) begin
              zeroed_d = 1'b1;
              ev       = EV_PASS;
            end else begin
              ev = EV_DONE;
            end
          end
          if (do_vstep) begin
            lvl_d     = step_lvl;
            zeroed_d  = 1'b0;
            elapsed_d = '0;
            ev        = EV_VSTEP;
          end
        end
        // protection looks at levels after this tick's step, also when idle
        for (int i = 0; i < CHANNELS; i++) begin
          if (tgt_q[i] != '0 && lvl_d[i] != '0 && item_i.limit_flags[i]) fault_hit = 1'b1;
        end
        if (cfg_i.protection_enable && fault_hit) begin
          fil_en_d = 1'b0;
          mode_d   = MODE_IDLE;
          ev       = EV_FAULT;
        end
      end
      default: ;  // unused command, state kept
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      zeroed_q   <= 1'b1;
      fil_lvl_q  <= '0;
      fil_goal_q <= '0;
      fil_en_q   <= 1'b0;
      beam_lim_q <= 1'b0;
      elapsed_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        lvl_q[i] <= '0;
        tgt_q[i] <= '0;
      end
    end else if (advance_i) begin
      mode_q     <= mode_d;
      lvl_q      <= lvl_d;
      tgt_q      <= tgt_d;
      zeroed_q   <= zeroed_d;
      fil_lvl_q  <= fil_lvl_d;
      fil_goal_q <= fil_goal_d;
      fil_en_q   <= fil_en_d;
      beam_lim_q <= beam_lim_d;
      elapsed_q  <= elapsed_d;
    end
  end

  // result reflects the state after this item
  always_comb begin
    result_o.ramp_state = mode_d;
    for (int s = 0; s < SLOTS; s++) begin
      result_o.volt[s] = '0;
    end
    for (int i = 0; i < CHANNELS; i++) begin
      result_o.volt[i] = zeroed_d ? '0 : SLOT_W'(lvl_d[i]);
    end
    result_o.filament_level = 16'(fil_lvl_d);
    result_o.filament_on    = fil_en_d;
    result_o.limit_set      = beam_lim_d;
    result_o.event_res      = ev;
  end

  // Assertions
  a_fault_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && ev == EV_FAULT |=> mode_q == MODE_IDLE && !fil_en_q)
    else $error("fault did not stop the sequence");

  a_vstep_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && ev == EV_VSTEP |=> elapsed_q == '0 && !zeroed_q)
    else $error("voltage step left timer or zeroing set");

  a_fil_lim : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fil_en_q |-> beam_lim_q && fil_lvl_q <= fil_goal_q)
    else $error("filament on without beam limits or above goal");

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
    a_lvl_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
      lvl_q[g] <= tgt_q[g])
      else $error("channel level above its target");
  end

endmodule

`default_nettype wire

/* rtl/hv_supply_ramp_sequencer.sv */
// Channel     Dir  Handshake                   Payload
// s_axis      in   s_axis_tvalid/tready        tuser: cmd; tdata: filament_target, limit_flags
// m_axis      out  m_axis_tvalid/tready        tuser: event_res; tdata: state, levels
// cfg         in   cfg_we_i (no wait)          cfg_index_i, cfg_data_i
//
// One result per input transfer; a transfer can be taken every cycle while
// m_axis is not stalled. Each item passes the input register, then the
// single-pass update into the result register.
// Stalls: the input register refills as the result register drains, so a held
// m_axis_tready stops s_axis only once both registers are full.
// Reset (rst_ni low, async): sequencer idle, levels zero, m_axis_tvalid low
// (result payload not reset), register file at its defaults.
`default_nettype none

module hv_supply_ramp_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // input stream
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // [15:0] filament_target, [19:16] limit_flags, [23:20] zero
  input  wire logic [hvs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] cmd
  input  wire logic [hvs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  // result stream
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] ramp_state, [17:2] volt_ch0, [33:18] volt_ch1, [49:34] volt_ch2,
  // [65:50] volt_ch3, [81:66] filament_level, [82] filament_on,
  // [83] limit_set, [87:84] zero
  output      logic [hvs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [2:0] event_res
  output      logic [hvs_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [hvs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [hvs_pkg::CFG_W-1:0]       cfg_data_i
);
  import hvs_pkg::*;

  hvs_cfg_t    cfg;
  hvs_item_t   item_q;
  hvs_result_t res_d, res_q;
  logic        in_vld_q, in_vld_d;
  logic        out_vld_q, out_vld_d;
  logic        advance, s_xfer;

  // item moves from input register to result register
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign in_vld_d  = s_xfer || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      item_q.cmd             <= s_axis_tuser[1:0];
      item_q.filament_target <= s_axis_tdata[15:0];
      item_q.limit_flags     <= s_axis_tdata[19:16];
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  hvs_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  hvs_seq_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (item_q),
    .result_o  (res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, res_q.limit_set, res_q.filament_on, res_q.filament_level,
                          res_q.volt[3], res_q.volt[2], res_q.volt[1], res_q.volt[0],
                          res_q.ramp_state};
  assign m_axis_tuser  = res_q.event_res;

endmodule

`default_nettype wire

/* bench/hv_supply_ramp_sequencer_tb.sv */
`timescale 1ns / 100ps

module hv_supply_ramp_sequencer_tb;
  import hvs_pkg::*;

  // cmd code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [15:0] LVL_MASK = 16'((32'd1 << LEVEL_BITS) - 1);
  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_ITEMS = 500;

  // Tracks the sequencer state per accepted command and queues the result each one is due
  // to produce; results from the block are checked against the head of that queue.
  class ramp_tracker;
    // register file
    logic [63:0] targets_reg;
    logic [15:0] vstep;
    logic [15:0] fstep;
    logic [31:0] step_per;
    logic [31:0] fil_per;
    logic [31:0] init_per;
    logic        prot_en;
    // sequencer state
    logic [1:0]  mode;
    logic [15:0] level [SLOTS];
    logic [15:0] goal_v [SLOTS];
    logic        zeroed;
    logic [15:0] fil_lvl;
    logic [15:0] fil_goal;
    logic        fil_en;
    logic        beam_lim;
    logic [31:0] elapsed;

    hvs_result_t ramp_results_due [$];
    int errors;

    function new();
      targets_reg = '0;
      vstep       = 16'd1;
      fstep       = 16'd1;
      step_per    = '0;
      fil_per     = '0;
      init_per    = '0;
      prot_en     = 1'b1;
      mode        = MODE_IDLE;
      foreach (level[i]) begin
        level[i]  = '0;
        goal_v[i] = '0;
      end
      zeroed   = 1'b1;
      fil_lvl  = '0;
      fil_goal = '0;
      fil_en   = 1'b0;
      beam_lim = 1'b0;
      elapsed  = '0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_VOLT_TARGETS: targets_reg = v;
        REG_VOLT_STEP:    vstep       = v[15:0];
        REG_FIL_STEP:     fstep       = v[15:0];
        REG_STEP_TICKS:   step_per    = v[31:0];
        REG_FIL_TICKS:    fil_per     = v[31:0];
        REG_INIT_TICKS:   init_per    = v[31:0];
        REG_PROT_EN:      prot_en     = v[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] sat_add(logic [15:0] lvl, logic [15:0] step, logic [15:0] goal);
      logic [16:0] sum;
      sum = {1'b0, lvl & LVL_MASK} + {1'b0, step};
      return (sum > {1'b0, goal}) ? goal : sum[15:0];
    endfunction

    function void start_run(logic [1:0] m, logic [15:0] goal);
      for (int i = 0; i < SLOTS; i++) begin
        level[i]  = '0;
        goal_v[i] = (i < CHANNELS) ? (targets_reg[16*i +: 16] & LVL_MASK) : '0;
      end
      mode     = m;
      zeroed   = 1'b1;
      fil_lvl  = '0;
      fil_goal = goal & LVL_MASK;
      fil_en   = 1'b0;
      beam_lim = (m == MODE_BEAM);
      elapsed  = '0;
    endfunction

    function void step_levels();
      for (int i = 0; i < CHANNELS && i < SLOTS; i++)
        level[i] = sat_add(level[i], vstep, goal_v[i]);
      zeroed  = 1'b0;
      elapsed = '0;
    endfunction

    // one tick of the ramp; filament first in beam-on, then the voltages
    function logic [2:0] advance();
      bit all_zero;
      bit all_on;
      all_zero = 1'b1;
      all_on   = 1'b1;
      if (mode != MODE_TEST && mode != MODE_BEAM)
        return EV_NONE;
      if (mode == MODE_BEAM && fil_goal != fil_lvl) begin
        if (elapsed < fil_per)
          return EV_NONE;
        if (fil_lvl == '0) begin
          fil_en   = 1'b1;
          beam_lim = 1'b1;
        end
        fil_lvl = sat_add(fil_lvl, fstep, fil_goal);
        elapsed = '0;
        return EV_FSTEP;
      end
      for (int i = 0; i < CHANNELS && i < SLOTS; i++) begin
        if (level[i] != '0) all_zero = 1'b0;
        if (level[i] != goal_v[i]) all_on = 1'b0;
      end
      if (all_zero) begin
        if (elapsed < init_per)
          return EV_NONE;
        step_levels();
        return EV_VSTEP;
      end
      if (!all_on) begin
        if (elapsed < step_per)
          return EV_NONE;
        step_levels();
        return EV_VSTEP;
      end
      if (mode == MODE_TEST) begin
        mode   = MODE_IDLE;
        zeroed = 1'b1;
        return EV_PASS;
      end
      mode = MODE_IDLE;
      return EV_DONE;
    endfunction

    // current-limit trip on a channel that has both a target and a level
    function bit trip(logic [3:0] flags);
      if (!prot_en)
        return 1'b0;
      for (int i = 0; i < CHANNELS && i < SLOTS; i++) begin
        if (goal_v[i] != '0 && level[i] != '0 && flags[i]) begin
          fil_en = 1'b0;
          mode   = MODE_IDLE;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void take_command(logic [1:0] cmd, logic [15:0] goal, logic [3:0] flags);
      hvs_result_t r;
      logic [2:0] ev;
      ev = EV_NONE;
      case (cmd)
        CMD_TEST: start_run(MODE_TEST, '0);
        CMD_BEAM: start_run(MODE_BEAM, goal);
        CMD_TICK: begin
          if (elapsed != '1)
            elapsed++;
          ev = advance();
          if (trip(flags))
            ev = EV_FAULT;
        end
        default: ;
      endcase
      r.ramp_state = mode;
      for (int i = 0; i < SLOTS; i++)
        r.volt[i] = (zeroed || i >= CHANNELS) ? '0 : level[i];
      r.filament_level = fil_lvl;
      r.filament_on    = fil_en;
      r.limit_set      = beam_lim;
      r.event_res      = ev;
      ramp_results_due.push_back(r);
    endfunction

    function void compare(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic [OUT_TUSER_W-1:0] tuser);
      hvs_result_t want;
      if (ramp_results_due.size() == 0) begin
        $display("%0t: unexpected result, tdata %h tuser %h", $time, tdata, tuser);
        errors++;
        return;
      end
      want = ramp_results_due.pop_front();
      compare("ramp_state", want.ramp_state, tdata[1:0]);
      for (int i = 0; i < SLOTS; i++)
        compare($sformatf("volt_ch%0d", i), want.volt[i], tdata[2 + 16*i +: 16]);
      compare("filament_level", want.filament_level, tdata[81:66]);
      compare("filament_on", want.filament_on, tdata[82]);
      compare("limit_set", want.limit_set, tdata[83]);
      compare("event_res", want.event_res, tuser[2:0]);
    endfunction

    function int pending();
      return ramp_results_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  ramp_tracker tracker = new();
  bit gaps_on = 1'b1;   // random idling on both sides
  int cycle_count = 0;

  hv_supply_ramp_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a correct run finishes far below this.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each transfer, then pick tready for the next edge.
  // Values read right after the edge are the ones the edge sampled.
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready)
      tracker.check_result(m_axis_tdata, m_axis_tuser);
    m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= 36) : 1'b1;
  end

  // Drive one command and hold it until the transfer. tvalid stays high
  // afterwards so back-to-back items need no extra assignment.
  task automatic send_item(logic [1:0] cmd, logic [15:0] goal, logic [3:0] flags);
    cfg_we_i <= 1'b0;
    while (gaps_on && $urandom_range(0, 99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, flags, goal};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    tracker.take_command(cmd, goal, flags);
  endtask

  // Register write; cfg_we_i is lowered by the next send_item.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    tracker.write_reg(idx, v);
  endtask

  // Stop sending, drain all results, then let the pipeline go quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_step();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(16'h1000, 16'hFFFF));
    endcase
  endfunction

  // mostly short periods so sequences run to completion
  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 11))
      0: return 32'hFFFF_FFFF;
      1: return $urandom;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    int sent;
    int phase;
    int n_items;
    int run_left;
    int r;
    logic [63:0] tv;
    logic [15:0] t;
    logic [1:0]  cmd;
    logic [15:0] goal;
    logic [3:0]  flags;

    sent     = 0;
    phase    = 0;
    run_left = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed: default registers, all targets zero ---
    // idle tick with every limit flag set: nothing active, no trip
    send_item(CMD_TICK, 16'hFFFF, 4'hF);
    send_item(CMD_UNUSED, 16'hFFFF, 4'hF);
    // zero targets: null voltage steps, never finishes
    send_item(CMD_TEST, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    // beam-on with zero filament goal skips the filament ramp
    send_item(CMD_BEAM, 16'h0000, 4'hF);
    send_item(CMD_TICK, 16'h0000, 4'hF);
    settle();

    cfg_write(REG_VOLT_TARGETS, 64'hFFFF_0001_8000_0003);
    cfg_write(REG_VOLT_STEP, 64'hFFFF);
    cfg_write(REG_FIL_STEP, 64'hFFFF);
    cfg_write(REG_STEP_TICKS, 64'd1);
    cfg_write(REG_FIL_TICKS, 64'd0);
    cfg_write(REG_INIT_TICKS, 64'd2);
    // full beam-on: filament step, init delay, one voltage step, done
    send_item(CMD_BEAM, 16'hFFFF, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    // trip while idle: levels are still up
    send_item(CMD_TICK, 16'h0000, 4'h8);
    // insulation test to pass
    send_item(CMD_TEST, 16'hFFFF, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    // trip mid beam-on on channel 0, overrides the ramp event
    send_item(CMD_BEAM, 16'h0001, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'h0000, 4'h1);
    settle();

    // protection off: flags are ignored
    cfg_write(REG_PROT_EN, 64'd0);
    send_item(CMD_BEAM, 16'h0000, 4'h0);
    send_item(CMD_TICK, 16'hFFFF, 4'hF);

    // --- random phases: each one a new register setting ---
    while (sent < RANDOM_ITEMS) begin
      settle();
      gaps_on = (phase != 3);   // one long stretch without idling

      for (int ch = 0; ch < SLOTS; ch++) begin
        case ($urandom_range(0, 7))
          0: t = 16'h0000;
          1: t = 16'hFFFF;
          default: t = 16'($urandom);
        endcase
        tv[16*ch +: 16] = t;
      end
      cfg_write(REG_VOLT_TARGETS, tv);
      cfg_write(REG_VOLT_STEP, 64'(rand_step()));
      cfg_write(REG_FIL_STEP, 64'(rand_step()));
      cfg_write(REG_STEP_TICKS, 64'(rand_period()));
      cfg_write(REG_FIL_TICKS, 64'(rand_period()));
      cfg_write(REG_INIT_TICKS, 64'(rand_period()));
      cfg_write(REG_PROT_EN, 64'($urandom_range(0, 3) != 0));
      // pinned extremes: one step then an endless step period; endless delays
      if (phase == 1) begin
        cfg_write(REG_VOLT_TARGETS, '1);
        cfg_write(REG_VOLT_STEP, 64'h8000);
        cfg_write(REG_INIT_TICKS, 64'd0);
        cfg_write(REG_STEP_TICKS, 64'hFFFF_FFFF);
      end
      if (phase == 2) begin
        cfg_write(REG_INIT_TICKS, 64'hFFFF_FFFF);
        cfg_write(REG_FIL_TICKS, 64'hFFFF_FFFF);
      end

      n_items  = (phase == 3) ? 120 : $urandom_range(30, 80);
      run_left = 0;
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0: goal = 16'h0000;
          1: goal = 16'hFFFF;
          default: goal = 16'($urandom);
        endcase
        flags = ($urandom_range(0, 99) < 88) ? 4'h0 : 4'($urandom);
        // mostly a start followed by a run of ticks, with some noise
        if (run_left == 0) begin
          cmd      = ($urandom_range(0, 1) != 0) ? CMD_BEAM : CMD_TEST;
          run_left = $urandom_range(8, 60);
        end else if (r < 4) begin
          cmd = CMD_UNUSED;
        end else if (r < 7) begin
          cmd = 2'($urandom);
        end else begin
          cmd      = CMD_TICK;
          run_left = run_left - 1;
        end
        send_item(cmd, goal, flags);
        if (cmd != CMD_UNUSED)
          sent++;
      end
      phase++;
    end

    gaps_on = 1'b1;
    settle();
    repeat (8) @(posedge clk_i);
    if (tracker.pending() != 0)
      $display("%0t: %0d results never arrived", $time, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
